// ===== design/lss_pkg.sv =====
// lss_pkg: shared types, widths and the step conductance table of the
// load step subset selector. No dependencies; every other design file imports it.
`default_nettype none

package lss_pkg;

  localparam int LSS_NUM_STEPS = 8;
  localparam int LSS_TABLE_LEN = 8;

  localparam int LSS_VOLTS_W = 10;
  localparam int LSS_AMPS_W  = 12;
  localparam int LSS_OHMS_W  = 16;
  localparam int LSS_MASK_W  = 8;
  localparam int LSS_DUTY_W  = 10;

  // conductance in Q0.16, largest entry stays below 2^15
  localparam int LSS_G_W    = 15;
  localparam int LSS_FRAC_W = 16;
  // one step current volts * G before truncation
  localparam int LSS_PROD_W = LSS_VOLTS_W + LSS_G_W;
  // all steps together, volts * sum(G) < 2^28
  localparam int LSS_SUM_W  = LSS_FRAC_W + LSS_AMPS_W;
  // shared multiplier operands and product
  localparam int LSS_MUL_A_W = LSS_AMPS_W;
  localparam int LSS_MUL_B_W = LSS_OHMS_W;
  localparam int LSS_NUM_W   = LSS_MUL_A_W + LSS_MUL_B_W;

  localparam logic [LSS_DUTY_W-1:0] LSS_DUTY_MAX   = 10'd1000;
  localparam logic [LSS_OHMS_W-1:0] LSS_OHMS_RESET = 16'd5000;

  localparam int LSS_CFG_ADDR_W = 3;
  localparam int LSS_CFG_DATA_W = 32;
  localparam logic LSS_REG_FINE_TUNE_OHMS = 1'b0;

  localparam logic [LSS_G_W-1:0] LSS_G [LSS_TABLE_LEN] = '{
    15'd19505, 15'd12071, 15'd9615, 15'd9748,
    15'd12632, 15'd11845, 15'd18778, 15'd12926
  };

  typedef struct packed {
    logic [LSS_MASK_W-1:0] step_mask;
    logic [LSS_DUTY_W-1:0] fine_tune_duty;
    logic                  steps_released;
  } lss_result_t;

  typedef struct packed {
    logic                   start;
    logic [LSS_NUM_W-1:0]   dividend;
    logic [LSS_VOLTS_W-1:0] divisor;
  } lss_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [LSS_NUM_W-1:0] quotient;
  } lss_div_rsp_t;

  // steps past the table draw no current
  function automatic logic [LSS_G_W-1:0] lss_conductance(input int j);
    logic [LSS_G_W-1:0] g;
    g = '0;
    if (j >= 0 && j < LSS_TABLE_LEN) begin
      g = LSS_G[j];
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== design/lss_in_if.sv =====
// lss_in_if: valid/ready channel carrying one set-point request.
// Depends on lss_pkg for field widths.
`default_nettype none

interface lss_in_if;
  import lss_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [LSS_VOLTS_W-1:0] measured_volts;
  logic [LSS_AMPS_W-1:0]  target_current;

  modport source (output valid, output measured_volts, output target_current, input ready);
  modport sink   (input valid, input measured_volts, input target_current, output ready);
endinterface

`default_nettype wire

// ===== design/lss_out_if.sv =====
// lss_out_if: valid/ready channel carrying one load setting.
// Depends on lss_pkg for field widths.
`default_nettype none

interface lss_out_if;
  import lss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LSS_MASK_W-1:0] step_mask;
  logic [LSS_DUTY_W-1:0] fine_tune_duty;
  logic                  steps_released;

  modport source (output valid, output step_mask, output fine_tune_duty,
                  output steps_released, input ready);
  modport sink   (input valid, input step_mask, input fine_tune_duty,
                  input steps_released, output ready);
endinterface

`default_nettype wire

// ===== design/lss_divider.sv =====
// lss_divider: restoring divider, one quotient bit per cycle.
// Depends on lss_pkg for the request and response structs.
`default_nettype none

module lss_divider (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lss_pkg::lss_div_req_t req,
  output lss_pkg::lss_div_rsp_t      rsp
);
  import lss_pkg::*;

  localparam int CNT_W = $clog2(LSS_NUM_W);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [LSS_NUM_W-1:0]   work_r, work_nxt;
  logic [LSS_VOLTS_W-1:0] rem_r, rem_nxt;
  logic [LSS_VOLTS_W-1:0] div_r, div_nxt;
  logic [LSS_VOLTS_W:0]   shifted;
  logic                   ge;

  assign shifted = {rem_r, work_r[LSS_NUM_W-1]};
  assign ge      = shifted >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(LSS_NUM_W - 1);
      work_nxt = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      // dividend bits shift out the top, quotient bits shift in below
      work_nxt = {work_r[LSS_NUM_W-2:0], ge};
      rem_nxt  = ge ? LSS_VOLTS_W'(shifted - {1'b0, div_r}) : shifted[LSS_VOLTS_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = work_r;

endmodule

`default_nettype wire

// ===== design/lss_core.sv =====
// lss_core: sequencer with one shared multiplier and a gray-code subset walk,
// followed by the fine-tune duty division. Depends on lss_pkg and lss_divider.
`default_nettype none

module lss_core #(
  parameter int NUM_STEPS = lss_pkg::LSS_NUM_STEPS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [lss_pkg::LSS_VOLTS_W-1:0] volts,
  input  wire logic [lss_pkg::LSS_AMPS_W-1:0]  target,
  input  wire logic [lss_pkg::LSS_OHMS_W-1:0]  ohms,
  output logic                                in_ready,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output lss_pkg::lss_result_t                res
);
  import lss_pkg::*;

  localparam int IDX_W  = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int MEXT_W = (NUM_STEPS > LSS_MASK_W) ? NUM_STEPS : LSS_MASK_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_SEARCH, S_MUL, S_DIV, S_DIVW, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LSS_VOLTS_W-1:0] volts_r, volts_nxt;
  logic [LSS_AMPS_W-1:0]  target_r, target_nxt;
  logic [IDX_W-1:0]       j_r, j_nxt;
  logic [NUM_STEPS-1:0]   i_r, i_nxt;
  logic [LSS_SUM_W-1:0]   sum_r, sum_nxt;
  logic [LSS_AMPS_W-1:0]  best_rem_r, best_rem_nxt;
  logic [NUM_STEPS-1:0]   best_mask_r, best_mask_nxt;
  logic [LSS_NUM_W-1:0]   num_r, num_nxt;
  lss_result_t            res_r, res_nxt;
  logic [LSS_PROD_W-1:0]  p_r [NUM_STEPS];

  logic [LSS_MUL_A_W-1:0] mul_a;
  logic [LSS_MUL_B_W-1:0] mul_b;
  logic [LSS_NUM_W-1:0]   mul_p;

  logic [IDX_W-1:0]       tz;
  logic [NUM_STEPS-1:0]   gray;
  logic [LSS_SUM_W-1:0]   sum_new;
  logic [LSS_AMPS_W-1:0]  amps_new;
  logic [LSS_AMPS_W-1:0]  rem_new;
  logic                   better;
  logic [MEXT_W-1:0]      mask_ext;

  lss_div_req_t div_req;
  lss_div_rsp_t div_rsp;

  // shared multiplier: step currents first, then remainder times milliohms
  always_comb begin
    if (state_r == S_PROD) begin
      mul_a = LSS_MUL_A_W'(volts_r);
      mul_b = LSS_MUL_B_W'(lss_conductance(int'(j_r)));
    end else begin
      mul_a = best_rem_r;
      mul_b = ohms;
    end
    mul_p = LSS_NUM_W'(mul_a * mul_b);
  end

  // bit that flips between consecutive gray codes is the lowest set bit of i
  always_comb begin
    tz = '0;
    for (int k = NUM_STEPS - 1; k >= 0; k--) begin
      if (i_r[k]) begin
        tz = IDX_W'(k);
      end
    end
  end

  assign gray     = i_r ^ (i_r >> 1);
  assign sum_new  = gray[tz] ? sum_r + LSS_SUM_W'(p_r[tz]) : sum_r - LSS_SUM_W'(p_r[tz]);
  assign amps_new = sum_new[LSS_SUM_W-1:LSS_FRAC_W];
  assign rem_new  = target_r - amps_new;
  assign better   = (amps_new <= target_r) &&
                    ((rem_new < best_rem_r) ||
                     ((rem_new == best_rem_r) && (gray < best_mask_r)));
  assign mask_ext = MEXT_W'(best_mask_r);

  assign div_req.start    = (state_r == S_DIV) && (num_r != '0);
  assign div_req.dividend = num_r;
  assign div_req.divisor  = volts_r;

  lss_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    volts_nxt     = volts_r;
    target_nxt    = target_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    sum_nxt       = sum_r;
    best_rem_nxt  = best_rem_r;
    best_mask_nxt = best_mask_r;
    num_nxt       = num_r;
    res_nxt       = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          volts_nxt  = volts;
          target_nxt = target;
          j_nxt      = '0;
          if (target == '0) begin
            res_nxt   = '{step_mask: '0, fine_tune_duty: '0, steps_released: 1'b1};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PROD;
          end
        end
      end
      S_PROD: begin
        j_nxt = j_r + IDX_W'(1);
        if (j_r == IDX_W'(NUM_STEPS - 1)) begin
          i_nxt         = NUM_STEPS'(1);
          sum_nxt       = '0;
          best_rem_nxt  = target_r;
          best_mask_nxt = '0;
          state_nxt     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        sum_nxt = sum_new;
        i_nxt   = i_r + NUM_STEPS'(1);
        if (better) begin
          best_rem_nxt  = rem_new;
          best_mask_nxt = gray;
        end
        if (i_r == '1) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        num_nxt   = mul_p;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        res_nxt.step_mask      = mask_ext[LSS_MASK_W-1:0];
        res_nxt.steps_released = 1'b0;
        if (num_r == '0) begin
          res_nxt.fine_tune_duty = '0;
          state_nxt              = S_DONE;
        end else begin
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          // zero volts divides to all ones and lands on the ceiling too
          res_nxt.fine_tune_duty = (div_rsp.quotient > LSS_NUM_W'(LSS_DUTY_MAX)) ?
                                   LSS_DUTY_MAX : div_rsp.quotient[LSS_DUTY_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    volts_r     <= volts_nxt;
    target_r    <= target_nxt;
    j_r         <= j_nxt;
    i_r         <= i_nxt;
    sum_r       <= sum_nxt;
    best_rem_r  <= best_rem_nxt;
    best_mask_r <= best_mask_nxt;
    num_r       <= num_nxt;
    res_r       <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PROD) begin
      p_r[j_r] <= mul_p[LSS_PROD_W-1:0];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

`ifndef ASSERT_OFF
  a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.steps_released |-> res.step_mask == '0 && res.fine_tune_duty == '0)
    else $error("released result carries steps or duty");
  a_duty_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res.fine_tune_duty <= LSS_DUTY_MAX)
    else $error("fine-tune duty above ceiling");
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIVW)
    else $error("divider finished outside the wait state");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_ready |=> !in_ready)
    else $error("accepted transaction did not make the core busy");
`endif

endmodule

`default_nettype wire

// ===== design/load_step_subset_selector.sv =====
// load_step_subset_selector: top level with the register port, the core and
// the result register. Depends on lss_pkg, lss_in_if, lss_out_if and lss_core.
//
// Usage:
//   in_if carries one set-point (measured_volts, target_current) per transaction;
//   out_if returns step_mask, fine_tune_duty and steps_released for it.
//   fine_tune_milliohms is written over the cfg_ APB port at byte address 0.
// Sequence:
//   nonzero target: step products on the shared multiplier, then the
//   gray-code subset walk (one add and compare per subset), one multiply,
//   one divider launch, then a wait on the divider before out_if.valid.
//   A zero target, a zero remainder or a zero fine_tune_milliohms skips the divider.
//   One transaction is in work at a time; in_if.ready is high while idle.
// Reset: synchronous active-low rst_n empties the result register, idles the
//   core and sets fine_tune_milliohms to 5000.
// Stall: a finished result waits in the output register; the core accepts
//   and works on the next transaction meanwhile and holds its own result
//   until the register frees.
`default_nettype none

module load_step_subset_selector #(
  parameter int NUM_STEPS = lss_pkg::LSS_NUM_STEPS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  lss_in_if.sink                                  in_if,
  lss_out_if.source                               out_if,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [lss_pkg::LSS_CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [lss_pkg::LSS_CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [lss_pkg::LSS_CFG_DATA_W-1:0] cfg_prdata,
  output logic                                    cfg_pready
);
  import lss_pkg::*;

  logic [LSS_OHMS_W-1:0] ohms_r;
  logic                  out_valid_r;
  lss_result_t           out_r;

  logic                  core_in_ready;
  logic                  core_res_valid;
  logic                  core_res_ready;
  lss_result_t           core_res;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ohms_r <= LSS_OHMS_RESET;
    end else if (cfg_wr && cfg_paddr[2] == LSS_REG_FINE_TUNE_OHMS) begin
      ohms_r <= cfg_pwdata[LSS_OHMS_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == LSS_REG_FINE_TUNE_OHMS) ?
                      LSS_CFG_DATA_W'(ohms_r) : '0;

  lss_core #(
    .NUM_STEPS(NUM_STEPS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_if.valid && core_in_ready),
    .volts    (in_if.measured_volts),
    .target   (in_if.target_current),
    .ohms     (ohms_r),
    .in_ready (core_in_ready),
    .res_valid(core_res_valid),
    .res_ready(core_res_ready),
    .res      (core_res)
  );

  assign in_if.ready    = core_in_ready;
  assign core_res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_r <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_ready && core_res_valid) begin
      out_r <= core_res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.step_mask      = out_r.step_mask;
  assign out_if.fine_tune_duty = out_r.fine_tune_duty;
  assign out_if.steps_released = out_r.steps_released;

endmodule

`default_nettype wire

// ===== verif/tb_load_step_subset_selector.sv =====
// tb_load_step_subset_selector: self-checking testbench for the load step subset selector.
// Depends on lss_pkg, lss_in_if, lss_out_if and load_step_subset_selector; drives
// set-points and register writes, predicts each load setting and checks it.
`default_nettype none

module tb_load_step_subset_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT_NS     = 250_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [LSS_CFG_ADDR_W-1:0] OHMS_ADDR =
    LSS_CFG_ADDR_W'(4 * int'(LSS_REG_FINE_TUNE_OHMS));

  // Q0.16 conductances of the fixed steps, 65536 / R rounded
  localparam int unsigned STEP_G_Q16 [8] = '{
    19505, 12071, 9615, 9748, 12632, 11845, 18778, 12926
  };

  logic clk;
  logic rst_n;

  lss_in_if  in_ch ();
  lss_out_if out_ch ();

  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [LSS_CFG_ADDR_W-1:0] cfg_paddr;
  logic [LSS_CFG_DATA_W-1:0] cfg_pwdata;
  logic [LSS_CFG_DATA_W-1:0] cfg_prdata;
  logic                      cfg_pready;

  load_step_subset_selector u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lss_result_t           expected_settings [$];
  logic [LSS_OHMS_W-1:0] fine_tune_ohms;
  int                    mismatch_count;
  bit                    steady_flow;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // whole amps drawn by the steps selected in mask
  function automatic int unsigned bank_amps(input logic [LSS_VOLTS_W-1:0] volts,
                                            input logic [LSS_MASK_W-1:0] mask);
    int unsigned acc;
    acc = 0;
    for (int j = 0; j < LSS_NUM_STEPS; j++) begin
      if (mask[j]) begin
        acc += volts * STEP_G_Q16[j];
      end
    end
    return acc >> 16;
  endfunction

  function automatic lss_result_t predict_load_setting(
      input logic [LSS_VOLTS_W-1:0] volts,
      input logic [LSS_AMPS_W-1:0]  amps_req,
      input logic [LSS_OHMS_W-1:0]  ohms);
    lss_result_t     res;
    int unsigned     best_left;
    int unsigned     amps;
    logic [LSS_MASK_W-1:0] best_mask;
    longint unsigned num;
    longint unsigned quot;
    res = '0;
    if (amps_req == '0) begin
      res.steps_released = 1'b1;
      return res;
    end
    best_left = amps_req;
    best_mask = '0;
    // ascending walk with strict compare keeps the lowest mask on a tie
    for (int m = 1; m < (1 << LSS_NUM_STEPS); m++) begin
      amps = bank_amps(volts, LSS_MASK_W'(m));
      if (amps <= amps_req && (amps_req - amps) < best_left) begin
        best_left = amps_req - amps;
        best_mask = LSS_MASK_W'(m);
      end
    end
    res.step_mask = best_mask;
    num = longint'(best_left) * longint'(ohms);
    if (num == 0) begin
      res.fine_tune_duty = '0;
    end else if (volts == '0) begin
      res.fine_tune_duty = LSS_DUTY_MAX;
    end else begin
      quot = num / volts;
      res.fine_tune_duty = (quot > LSS_DUTY_MAX) ? LSS_DUTY_MAX : LSS_DUTY_W'(quot);
    end
    return res;
  endfunction

  // mostly short idle runs, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 30);
    return $urandom_range(100, 400);
  endfunction

  task automatic note_mismatch(input string what, input int unsigned exp_val,
                               input int unsigned act_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_val,
               act_val);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    lss_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_settings.size() == 0) begin
        note_mismatch("unexpected transaction, step_mask", 0, out_ch.step_mask);
      end else begin
        exp_res = expected_settings.pop_front();
        if (out_ch.step_mask !== exp_res.step_mask)
          note_mismatch("step_mask", exp_res.step_mask, out_ch.step_mask);
        if (out_ch.fine_tune_duty !== exp_res.fine_tune_duty)
          note_mismatch("fine_tune_duty", exp_res.fine_tune_duty, out_ch.fine_tune_duty);
        if (out_ch.steps_released !== exp_res.steps_released)
          note_mismatch("steps_released", exp_res.steps_released, out_ch.steps_released);
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady_flow || stall_left == 0) begin
        out_ch.ready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 99) < 25) stall_left = idle_len();
      end else begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end
    end
  end

  task automatic send_setpoint(input logic [LSS_VOLTS_W-1:0] volts,
                               input logic [LSS_AMPS_W-1:0]  amps_req);
    int gap;
    gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid          <= 1'b0;
      in_ch.measured_volts <= LSS_VOLTS_W'($urandom);
      in_ch.target_current <= LSS_AMPS_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.measured_volts <= volts;
    in_ch.target_current <= amps_req;
    do @(posedge clk); while (!in_ch.ready);
    expected_settings.push_back(predict_load_setting(volts, amps_req, fine_tune_ohms));
  endtask

  // stop sending and wait until every load setting has come back
  task automatic drain_settings();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_settings.size() != 0) @(posedge clk);
  endtask

  // drain outstanding settings, write the fine-tune resistance, then read it back
  task automatic program_fine_tune(input logic [LSS_OHMS_W-1:0] ohms);
    drain_settings();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= OHMS_ADDR;
    cfg_pwdata  <= {LSS_CFG_DATA_W'($urandom) >> LSS_OHMS_W << LSS_OHMS_W} | ohms;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    fine_tune_ohms = ohms;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== LSS_CFG_DATA_W'(ohms))
      note_mismatch("fine_tune_milliohms readback", ohms, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_edge_setpoints();
    send_setpoint(10'd0, 12'd0);
    send_setpoint(10'd1023, 12'd0);
    send_setpoint(10'd1023, 12'd4095);
    send_setpoint(10'd0, 12'd4095);
    send_setpoint(10'd0, 12'd1);
    send_setpoint(10'd1, 12'd1);
    send_setpoint(10'd1023, LSS_AMPS_W'(bank_amps(10'd1023, 8'hFF)));
    send_setpoint(10'd517, LSS_AMPS_W'(bank_amps(10'd517, 8'hA5)));
    send_setpoint(10'd700, LSS_AMPS_W'(bank_amps(10'd700, 8'h01)));
    send_setpoint(10'd1023, 12'd1);
    send_setpoint(10'd12, 12'd3);
    send_setpoint(10'd1023, 12'd1000);
    send_setpoint(10'd1, 12'd4095);
    send_setpoint(10'd512, 12'd2048);
  endtask

  task automatic test_fine_tune_extremes();
    // zero resistance leaves no duty even with amps left over
    program_fine_tune(16'd0);
    send_setpoint(10'd100, 12'd50);
    send_setpoint(10'd0, 12'd7);
    send_setpoint(10'd1023, 12'd4095);
    program_fine_tune(16'hFFFF);
    send_setpoint(10'd1023, 12'd1000);
    send_setpoint(10'd1023, LSS_AMPS_W'(bank_amps(10'd1023, 8'h3C) + 1));
    send_setpoint(10'd3, 12'd1);
    program_fine_tune(16'd1);
    send_setpoint(10'd1023, 12'd2000);
    send_setpoint(10'd2, 12'd4095);
  endtask

  task automatic test_random_setpoints(input int count, input logic [LSS_OHMS_W-1:0] ohms);
    logic [LSS_VOLTS_W-1:0] volts;
    int unsigned            amps_req;
    int                     pick;
    program_fine_tune(ohms);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 5) volts = '0;
      else if (pick < 10) volts = '1;
      else if (pick < 20) volts = LSS_VOLTS_W'($urandom_range(0, 15));
      else volts = LSS_VOLTS_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        amps_req = 0;
      end else if (pick < 48) begin
        // on or just above a reachable subset current
        amps_req = bank_amps(volts, LSS_MASK_W'($urandom)) + $urandom_range(0, 3);
        if (amps_req == 0) amps_req = $urandom_range(1, 3);
      end else if (pick < 60) begin
        amps_req = $urandom_range(3000, 4095);
      end else begin
        amps_req = $urandom_range(0, 4095);
      end
      send_setpoint(volts, LSS_AMPS_W'(amps_req));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n                = 1'b0;
    steady_flow          = 1'b0;
    mismatch_count       = 0;
    fine_tune_ohms       = LSS_OHMS_RESET;
    in_ch.valid          = 1'b0;
    in_ch.measured_volts = '0;
    in_ch.target_current = '0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_edge_setpoints();
    test_fine_tune_extremes();
    test_random_setpoints(292, LSS_OHMS_RESET);
    test_random_setpoints(292, 16'd1);
    test_random_setpoints(292, 16'hFFFF);
    test_random_setpoints(292, LSS_OHMS_W'($urandom_range(1, 65535)));
    test_random_setpoints(292, LSS_OHMS_W'($urandom_range(1, 300)));
    test_random_setpoints(292, 16'd0);

    drain_settings();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_settings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
